// ===== src/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helper functions for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    // Parser position within the literal
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_HEX2 = 3'd4,
        MODE_HEX3 = 3'd5,
        MODE_HEX4 = 3'd6
    } mode_t;

    // Result kind carried on the status port
    typedef enum logic [1:0] {
        ST_BYTE  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    localparam int unsigned MAX_RESULTS = 3;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // UTF-8 lead and continuation marks
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;
    localparam logic [15:0] UTF_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF_TWO_LIMIT = 16'h0800;

    // Up to three results produced by one input beat, first in slot 0
    typedef struct packed {
        logic [1:0]                   count;
        status_t                      status;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
    } res_group_t;

    // Hex digit value; bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] h);
        logic [4:0] r;
        r = '0;
        if (h >= 8'h30 && h <= 8'h39)
            r = {1'b1, h[3:0]};
        else if ((h >= 8'h61 && h <= 8'h66) || (h >= 8'h41 && h <= 8'h46))
            r = {1'b1, h[3:0] + 4'd9};
        return r;
    endfunction

    // Single-letter escape; bit 8 flags a valid letter
    function automatic logic [8:0] escape_map(input logic [7:0] e);
        logic [8:0] r;
        r = '0;
        case (e)
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_SLASH:  r = {1'b1, CH_SLASH};
            CH_LOW_B:  r = {1'b1, CH_BS};
            CH_LOW_F:  r = {1'b1, CH_FF};
            CH_LOW_N:  r = {1'b1, CH_LF};
            CH_LOW_R:  r = {1'b1, CH_CR};
            CH_LOW_T:  r = {1'b1, CH_TAB};
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// Parser state and the per-beat decode of one payload byte into a group of
// zero to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         in_byte,
    input  wire logic               end_of_source,
    input  wire logic               advance,
    output jsu_pkg::res_group_t     grp
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [15:0] cp_reg, cp_next;
    logic [15:0] cp_shift;
    logic [4:0]  hex;
    logic [8:0]  esc;
    logic        blank;

    assign hex      = hex_digit(in_byte);
    assign esc      = escape_map(in_byte);
    assign cp_shift = {cp_reg[11:0], hex[3:0]};
    assign blank    = (in_byte == CH_SPACE || in_byte == CH_TAB ||
                       in_byte == CH_CR || in_byte == CH_LF);

    // Next parser position and code point
    always_comb
    begin
        mode_next = mode_reg;
        cp_next   = cp_reg;
        case (mode_reg)
            MODE_STR:
            begin
                if (in_byte == CH_QUOTE || end_of_source)
                    mode_next = MODE_IDLE;
                else if (in_byte == CH_BSLASH)
                    mode_next = MODE_ESC;
            end
            MODE_ESC:
            begin
                if (in_byte == CH_LOW_U && !end_of_source)
                begin
                    cp_next   = '0;
                    mode_next = MODE_HEX1;
                end
                else if (esc[8] && !end_of_source)
                    mode_next = MODE_STR;
                else
                    mode_next = MODE_IDLE;
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4:
            begin
                if (!hex[4] || end_of_source)
                    mode_next = MODE_IDLE;
                else
                begin
                    cp_next = cp_shift;
                    case (mode_reg)
                        MODE_HEX1: mode_next = MODE_HEX2;
                        MODE_HEX2: mode_next = MODE_HEX3;
                        MODE_HEX3: mode_next = MODE_HEX4;
                        default:   mode_next = MODE_STR;
                    endcase
                end
            end
            default:
            begin
                // Idle, and the unused code: wait for the quote
                if (in_byte == CH_QUOTE && !end_of_source)
                    mode_next = MODE_STR;
                else
                    mode_next = MODE_IDLE;
            end
        endcase
    end

    // Results caused by this beat
    always_comb
    begin
        grp        = '0;
        grp.status = ST_BYTE;
        case (mode_reg)
            MODE_STR:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    grp.count  = 2'd1;
                    grp.status = ST_DONE;
                end
                else if (end_of_source)
                begin
                    grp.count  = 2'd1;
                    grp.status = ST_ERROR;
                end
                else if (in_byte != CH_BSLASH)
                begin
                    grp.count    = 2'd1;
                    grp.bytes[0] = in_byte;
                end
            end
            MODE_ESC:
            begin
                if (esc[8] && !end_of_source)
                begin
                    grp.count    = 2'd1;
                    grp.bytes[0] = esc[7:0];
                end
                else if (in_byte != CH_LOW_U || end_of_source)
                begin
                    grp.count  = 2'd1;
                    grp.status = ST_ERROR;
                end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4:
            begin
                if (!hex[4] || end_of_source)
                begin
                    grp.count  = 2'd1;
                    grp.status = ST_ERROR;
                end
                else if (mode_reg == MODE_HEX4)
                begin
                    if (cp_shift < UTF_ONE_LIMIT)
                    begin
                        grp.count    = 2'd1;
                        grp.bytes[0] = cp_shift[7:0];
                    end
                    else if (cp_shift < UTF_TWO_LIMIT)
                    begin
                        grp.count    = 2'd2;
                        grp.bytes[0] = UTF_LEAD2 | {3'b000, cp_shift[10:6]};
                        grp.bytes[1] = UTF_CONT | {2'b00, cp_shift[5:0]};
                    end
                    else
                    begin
                        grp.count    = 2'd3;
                        grp.bytes[0] = UTF_LEAD3 | {4'b0000, cp_shift[15:12]};
                        grp.bytes[1] = UTF_CONT | {2'b00, cp_shift[11:6]};
                        grp.bytes[2] = UTF_CONT | {2'b00, cp_shift[5:0]};
                    end
                end
            end
            default:
            begin
                // Skip blanks, open on a quote, reject the rest or an early end
                if (end_of_source || !(blank || in_byte == CH_QUOTE))
                begin
                    grp.count  = 2'd1;
                    grp.status = ST_ERROR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cp_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            cp_reg   <= cp_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/jsu_serial.sv =====
// ----------------------------------------------------------------------------
// jsu_serial
// Result register: holds one decoded group and hands its results out one
// beat at a time, reloading as the last one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_serial (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire jsu_pkg::res_group_t grp,
    output logic                    can_load,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_byte,
    output logic [1:0]              status,
    output logic                    last_of_run
);
    import jsu_pkg::*;

    logic [1:0]                  cnt_reg, cnt_next;
    logic [1:0]                  idx_reg, idx_next;
    status_t                     st_reg;
    logic [MAX_RESULTS-1:0][7:0] data_reg;
    logic                        take;
    logic                        is_last;

    assign out_valid   = (cnt_reg != 2'd0);
    assign is_last     = (idx_reg == cnt_reg - 2'd1);
    assign take        = out_valid && !out_stall;
    assign can_load    = !out_valid || (take && is_last);
    assign out_byte    = data_reg[idx_reg];
    assign status      = st_reg;
    assign last_of_run = is_last;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = grp.count;
            idx_next = '0;
        end
        else if (take)
        begin
            if (is_last)
                cnt_next = '0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_reg   <= grp.status;
            data_reg <= grp.bytes;
        end
    end

endmodule

`default_nettype wire

// ===== src/json_string_unescaper_top.sv =====
// ----------------------------------------------------------------------------
// json_string_unescaper_top
// Decodes one JSON string literal from a byte stream into raw UTF-8 bytes.
// ----------------------------------------------------------------------------
// Bytes enter one per beat on the input channel. Leading space, tab, CR and
// LF are skipped; the opening quote starts the string, and every string byte
// then comes out as a result with status 0. Escapes \" \\ \/ \b \f \n \r \t
// give one byte; \uXXXX gives one, two or three UTF-8 bytes once its fourth
// hex digit arrives (surrogates are encoded singly, never paired). The
// closing quote yields status 1, and any malformed byte, or a final byte
// that is not the closing quote, yields status 2; both return the parser to
// idle. last_of_run marks the final result caused by an input byte. Rate:
// one input byte per cycle while each byte causes at most one result and no
// stall comes from the output; a \u escape's three-byte result leaves the
// result register one result per cycle while out_stall is low. A byte passes
// through the input register and then the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescaper_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_source,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic [1:0]      status,
    output logic            last_of_run
);
    import jsu_pkg::*;

    // Input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    res_group_t grp;
    logic       can_load;
    logic       consume;
    logic       load;

    // A beat with no results leaves at once; otherwise it waits for the
    // result register to free up (or to free up in this same cycle).
    assign consume  = in_vld_reg && ((grp.count == 2'd0) || can_load);
    assign load     = consume && (grp.count != 2'd0);
    assign in_stall = in_vld_reg && !consume;

    assign in_vld_next = in_stall ? in_vld_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    // Hold the payload while stalled; capture on every accepted beat
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
            in_eos_reg  <= end_of_source;
        end
    end

    jsu_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (in_byte_reg),
        .end_of_source (in_eos_reg),
        .advance       (consume),
        .grp           (grp)
    );

    jsu_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .grp         (grp),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== src/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result channel of the unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic [1:0] status,
    input  wire logic       last_of_run
);
    import jsu_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) &&
            $stable(status) && $stable(last_of_run))
        else $error("stalled result beat changed");

    // Completion and error stand alone for their input byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_DONE || status == ST_ERROR) |-> last_of_run)
        else $error("status beat not marked last");

    // Non-byte results carry a zero byte
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_BYTE |-> out_byte == 8'h00)
        else $error("status beat with nonzero byte");

    // Status code stays within its defined range
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_BYTE || status == ST_DONE || status == ST_ERROR))
        else $error("undefined status code");

endmodule

bind json_string_unescaper_top jsu_checker u_jsu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .status      (status),
    .last_of_run (last_of_run)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JSON string unescaper.
// ----------------------------------------------------------------------------
// Feeds payload bytes through a valid/stall driver and checks every decoded
// result against an in-bench model of the parser. The model tracks the parse
// position and the \u code point. It predicts the decoded bytes, the
// completion and error reports, and the last-of-run marks.
// Stimulus is a short directed string followed by random string literals.
// Most are well formed, and the rest are broken in one place: bad leading
// byte, bad escape, bad hex digit, or an end of source that comes too early.
// ----------------------------------------------------------------------------

module testbench;

    import jsu_pkg::*;

    // One input beat as queued for the driver
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } src_beat_t;

    // One decoded result as the parser should deliver it
    typedef struct packed {
        logic [7:0] data;
        status_t    kind;
        logic       last;
    } decoded_t;

    localparam int HOLD_CYCLES = 64;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;  // settle time after the last result
    localparam int PHASE_BEATS = 28;   // input beats queued per random phase

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_source = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;

    // Payload bytes waiting to be driven, and decoded results still owed
    src_beat_t pending_bytes[$];
    decoded_t  owed_results[$];

    int          queued_beats = 0;
    int          accepted_beats = 0;
    int          phase_beats = 0;
    int          mismatch_count = 0;
    int unsigned send_gap_pct = 27;
    int unsigned recv_stall_pct = 54;
    logic        hold_armed = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_count = 0;
    int          esc_turn = 0;

    // Parser state as the bench sees it
    mode_t       parse_mode = MODE_IDLE;
    logic [15:0] cp_acc = 16'h0000;

    src_beat_t next_beat;
    decoded_t  want;

    json_string_unescaper_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_source (end_of_source),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .status        (status),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Character classes for the model
    // ------------------------------------------------------------------------

    // Value of a hex digit of either case, or -1
    function automatic int nibble_of(input logic [7:0] h);
        if (h >= 8'h30 && h <= 8'h39)
            return int'(h) - 'h30;
        if (h >= 8'h61 && h <= 8'h66)
            return int'(h) - 'h61 + 10;
        if (h >= 8'h41 && h <= 8'h46)
            return int'(h) - 'h41 + 10;
        return -1;
    endfunction

    // Byte for a single-letter escape, or -1
    function automatic int escape_target(input logic [7:0] e);
        case (e)
            CH_QUOTE:  return int'(CH_QUOTE);
            CH_BSLASH: return int'(CH_BSLASH);
            CH_SLASH:  return int'(CH_SLASH);
            CH_LOW_B:  return int'(CH_BS);
            CH_LOW_F:  return int'(CH_FF);
            CH_LOW_N:  return int'(CH_LF);
            CH_LOW_R:  return int'(CH_CR);
            CH_LOW_T:  return int'(CH_TAB);
            default:   return -1;
        endcase
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    // ------------------------------------------------------------------------
    // Model: advance the parser by one accepted byte and queue what it owes
    // ------------------------------------------------------------------------
    task automatic predict_beat(input logic [7:0] b, input logic eos);
        logic [7:0] run_bytes [3];
        int         n_bytes;
        status_t    run_kind;
        int         nib;
        int         esc;
        decoded_t   r;
        n_bytes = 0;
        run_kind = ST_BYTE;
        case (parse_mode)
            MODE_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    parse_mode = MODE_IDLE;
                    run_kind = ST_DONE;
                end
                else if (eos)
                begin
                    parse_mode = MODE_IDLE;
                    run_kind = ST_ERROR;
                end
                else if (b == CH_BSLASH)
                    parse_mode = MODE_ESC;
                else
                begin
                    run_bytes[0] = b;
                    n_bytes = 1;
                end
            end
            MODE_ESC:
            begin
                esc = escape_target(b);
                if (b == CH_LOW_U && !eos)
                begin
                    cp_acc = 16'h0000;
                    parse_mode = MODE_HEX1;
                end
                else if (esc < 0 || eos)
                begin
                    parse_mode = MODE_IDLE;
                    run_kind = ST_ERROR;
                end
                else
                begin
                    parse_mode = MODE_STR;
                    run_bytes[0] = esc[7:0];
                    n_bytes = 1;
                end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4:
            begin
                nib = nibble_of(b);
                if (nib < 0 || eos)
                begin
                    parse_mode = MODE_IDLE;
                    run_kind = ST_ERROR;
                end
                else
                begin
                    cp_acc = {cp_acc[11:0], nib[3:0]};
                    if (parse_mode != MODE_HEX4)
                        parse_mode = mode_t'(parse_mode + 3'd1);
                    else
                    begin
                        // Encode the gathered code point; surrogates stand alone
                        parse_mode = MODE_STR;
                        if (cp_acc < UTF_ONE_LIMIT)
                        begin
                            run_bytes[0] = cp_acc[7:0];
                            n_bytes = 1;
                        end
                        else if (cp_acc < UTF_TWO_LIMIT)
                        begin
                            run_bytes[0] = UTF_LEAD2 | {3'b000, cp_acc[10:6]};
                            run_bytes[1] = UTF_CONT | {2'b00, cp_acc[5:0]};
                            n_bytes = 2;
                        end
                        else
                        begin
                            run_bytes[0] = UTF_LEAD3 | {4'b0000, cp_acc[15:12]};
                            run_bytes[1] = UTF_CONT | {2'b00, cp_acc[11:6]};
                            run_bytes[2] = UTF_CONT | {2'b00, cp_acc[5:0]};
                            n_bytes = 3;
                        end
                    end
                end
            end
            default:
            begin
                // Idle: skip blanks, open on a quote, reject the rest
                parse_mode = MODE_IDLE;
                if (is_blank(b))
                begin
                    if (eos)
                        run_kind = ST_ERROR;
                end
                else if (b == CH_QUOTE && !eos)
                    parse_mode = MODE_STR;
                else
                    run_kind = ST_ERROR;
            end
        endcase
        if (run_kind != ST_BYTE)
        begin
            r.data = 8'h00;
            r.kind = run_kind;
            r.last = 1'b1;
            owed_results.push_back(r);
        end
        else
        begin
            for (int k = 0; k < n_bytes; k++)
            begin
                r.data = run_bytes[k];
                r.kind = ST_BYTE;
                r.last = (k == n_bytes - 1);
                owed_results.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_beat(input logic [7:0] b, input logic eos);
        src_beat_t s;
        s.data = b;
        s.last = eos;
        pending_bytes.push_back(s);
        queued_beats++;
        phase_beats++;
    endtask

    // Hex digit for a nibble, letters in random case
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + nib;
        if ($urandom_range(0, 1) == 0)
            return 8'h41 + (nib - 4'd10);
        return 8'h61 + (nib - 4'd10);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    // Rotate through the single-letter escapes so each one turns up
    function automatic logic [7:0] next_escape();
        logic [7:0] letters [8];
        letters = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B,
                    CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};
        esc_turn = (esc_turn + 1) % 8;
        return letters[esc_turn];
    endfunction

    // One string literal with random content; a quarter are broken somewhere
    task automatic queue_string();
        int          flaw;
        int          n_ws;
        int          n_body;
        int          n_dig;
        logic [7:0]  b;
        logic [15:0] cp;
        flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        n_ws = $urandom_range(0, 2);
        for (int k = 0; k < n_ws; k++)
            queue_beat(blank_char(), 1'b0);
        if (flaw == 1)
        begin
            // Leading byte that is neither blank nor quote
            do
                b = 8'($urandom_range(0, 255));
            while (is_blank(b) || b == CH_QUOTE);
            queue_beat(b, 1'($urandom_range(0, 1)));
            return;
        end
        if (flaw == 5)
        begin
            queue_beat(CH_QUOTE, 1'b1);
            return;
        end
        if (flaw == 6)
        begin
            queue_beat(blank_char(), 1'b1);
            return;
        end
        queue_beat(CH_QUOTE, 1'b0);
        n_body = $urandom_range(0, 6);
        for (int k = 0; k < n_body; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    queue_beat(plain_char(), 1'b0);
                5, 6, 7:
                begin
                    queue_beat(CH_BSLASH, 1'b0);
                    queue_beat(next_escape(), 1'b0);
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                        1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    endcase
                    queue_beat(CH_BSLASH, 1'b0);
                    queue_beat(CH_LOW_U, 1'b0);
                    for (int d = 3; d >= 0; d--)
                        queue_beat(hex_char(cp[d*4 +: 4]), 1'b0);
                end
            endcase
        end
        case (flaw)
            2:
            begin
                // Escape letter outside the set
                queue_beat(CH_BSLASH, 1'b0);
                do
                    b = 8'($urandom_range(0, 255));
                while (escape_target(b) >= 0 || b == CH_LOW_U);
                queue_beat(b, 1'b0);
            end
            3:
            begin
                // Non-hex byte somewhere in a \u escape
                queue_beat(CH_BSLASH, 1'b0);
                queue_beat(CH_LOW_U, 1'b0);
                n_dig = $urandom_range(0, 3);
                for (int d = 0; d < n_dig; d++)
                    queue_beat(hex_char(4'($urandom_range(0, 15))), 1'b0);
                do
                    b = 8'($urandom_range(0, 255));
                while (nibble_of(b) >= 0);
                queue_beat(b, 1'b0);
            end
            4:
            begin
                // Source ends inside the string, even on a good byte
                case ($urandom_range(0, 4))
                    0:
                        queue_beat(plain_char(), 1'b1);
                    1:
                        queue_beat(CH_BSLASH, 1'b1);
                    2:
                    begin
                        queue_beat(CH_BSLASH, 1'b0);
                        queue_beat(next_escape(), 1'b1);
                    end
                    3:
                    begin
                        queue_beat(CH_BSLASH, 1'b0);
                        queue_beat(CH_LOW_U, 1'b1);
                    end
                    default:
                    begin
                        queue_beat(CH_BSLASH, 1'b0);
                        queue_beat(CH_LOW_U, 1'b0);
                        n_dig = $urandom_range(0, 3);
                        for (int d = 0; d < n_dig; d++)
                            queue_beat(hex_char(4'($urandom_range(0, 15))), 1'b0);
                        queue_beat(hex_char(4'($urandom_range(0, 15))), 1'b1);
                    end
                endcase
            end
            default:
                queue_beat(CH_QUOTE, 1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: hold the payload while stalled, advance once a beat is taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte <= 8'h00;
            end_of_source <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_beat(in_byte, end_of_source);
                accepted_beats++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    next_beat = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    in_byte <= next_beat.data;
                    end_of_source <= next_beat.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: random, apart from one long hold-off once armed
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_count <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
                report_mismatch($sformatf("result with none owed: byte %02h status %0d last %0b",
                                          out_byte, status, last_of_run));
            else
            begin
                want = owed_results.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
                if (status !== want.kind)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.kind));
                if (last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, want %0b",
                                              last_of_run, want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed string, three random phases, drain, verdict
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: blanks, extremes of the byte range, two- and three-byte
        // \u forms in mixed case, a closed string, then three kinds of error
        queue_beat(CH_SPACE, 1'b0);
        queue_beat(CH_TAB, 1'b0);
        queue_beat(CH_QUOTE, 1'b0);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(CH_BSLASH, 1'b0);
        queue_beat(CH_LOW_U, 1'b0);
        queue_beat(8'h30, 1'b0);   // 0
        queue_beat(8'h37, 1'b0);   // 7
        queue_beat(8'h66, 1'b0);   // f
        queue_beat(8'h46, 1'b0);   // F
        queue_beat(CH_BSLASH, 1'b0);
        queue_beat(CH_LOW_U, 1'b0);
        queue_beat(8'h61, 1'b0);   // a
        queue_beat(8'h42, 1'b0);   // B
        queue_beat(8'h63, 1'b0);   // c
        queue_beat(8'h44, 1'b0);   // D
        queue_beat(CH_QUOTE, 1'b0);
        queue_beat(8'h78, 1'b0);   // stray byte before the quote
        queue_beat(CH_QUOTE, 1'b0);
        queue_beat(CH_BSLASH, 1'b0);
        queue_beat(8'h71, 1'b0);   // unknown escape letter
        queue_beat(CH_QUOTE, 1'b0);
        queue_beat(CH_BSLASH, 1'b0);
        queue_beat(CH_LOW_U, 1'b0);
        queue_beat(8'h67, 1'b0);   // not a hex digit

        // Sender sparse-ish, receiver stalling more
        phase_beats = 0;
        while (phase_beats < PHASE_BEATS)
            queue_string();
        while (pending_bytes.size() != 0)
            @(posedge clk);

        // Swap the idle rates
        send_gap_pct <= 54;
        recv_stall_pct <= 27;
        phase_beats = 0;
        while (phase_beats < PHASE_BEATS)
            queue_string();
        while (pending_bytes.size() != 0)
            @(posedge clk);

        // Full rate, opening with a long receiver hold-off so the block backs up
        send_gap_pct <= 0;
        recv_stall_pct <= 0;
        phase_beats = 0;
        while (phase_beats < PHASE_BEATS)
            queue_string();
        hold_armed <= 1'b1;

        while (accepted_beats != queued_beats || owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/jsu_pkg.sv
src/jsu_decode.sv
src/jsu_serial.sv
src/json_string_unescaper_top.sv
src/jsu_checker.sv
bench/testbench.sv
